@@ rtl/brbf_pkg.sv @@
// ----------------------------------------------------------------------------
// brbf_pkg
// Shared types and constants for the circular byte FIFO.
// ----------------------------------------------------------------------------
package brbf_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned LevelW = 9;

  // Input tdata carries data_byte and count; output tdata carries
  // out_byte, done_count and fill_level.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 2;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_OVR  = 3'd0,
    OP_PUSH_ROOM = 3'd1,
    OP_POP       = 3'd2,
    OP_PEEK      = 3'd3,
    OP_DROP      = 3'd4
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_e;

  // One result record, without its byte. Records with byte_valid set take
  // their byte from the storage read register.
  typedef struct packed {
    logic              byte_valid;
    logic              accepted;
    logic [CountW-1:0] done_count;
    logic              last;
    logic [LevelW-1:0] fill_level;
  } rec_t;

endpackage

@@ rtl/byte_ring_buffer_fifo_top.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_fifo_top
// Circular byte FIFO kept in a synchronous memory, with push, pop, peek and
// drop operations and a programmable ring capacity.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  --------  ---------  -----------------------------------------------------
//  s_axis    in         tuser = op; tdata = data_byte, count
//  m_axis    out        tuser = byte_valid, accepted; tdata = out_byte,
//                       done_count, fill_level; tlast = last
//  cfg       in         cfg_we_i / cfg_wdata_i write the capacity register
//
// Pushes, drops and unknown operations each produce one transaction. A pop or
// peek of n bytes gives n transactions, since the byte store's single read port
// delivers one byte per cycle while the output path has room; n is the request
// capped at MAX_BURST and at the fill level. A new input transaction is taken
// no earlier than the cycle after the one that issues the last read of a burst.
// Reset clears the head, fill count and pipeline and loads the capacity; the
// byte store is not cleared, since only entries that were written are read.
// Output stalls hold results in the memory read register and the output
// register, and the input side waits until that two-stage path has room.
//
module byte_ring_buffer_fifo_top #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // Capacity register.
  input  logic                           cfg_we_i,
  input  logic [brbf_pkg::LevelW-1:0]    cfg_wdata_i,

  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] data_byte, [14:8] count, [15] zero
  input  logic [brbf_pkg::InDataW-1:0]   s_axis_tdata,
  // [2:0] op
  input  logic [brbf_pkg::OpW-1:0]       s_axis_tuser,

  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] out_byte, [14:8] done_count, [23:15] fill_level
  output logic [brbf_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] byte_valid, [1] accepted
  output logic [brbf_pkg::OutUserW-1:0]  m_axis_tuser,
  output logic                           m_axis_tlast
);

  import brbf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LevelW-1:0] CapRst = LevelW'((DEPTH < 256) ? DEPTH : 256);
  localparam logic [CountW-1:0] BurstMax = CountW'(MAX_BURST);

  // Ring addition: both operands stay within the capacity, so a single
  // conditional subtract brings the sum back into the ring.
  function automatic logic [LevelW-1:0] wrap_add(input logic [LevelW-1:0] a,
                                                 input logic [LevelW-1:0] b,
                                                 input logic [LevelW-1:0] cap);
    logic [LevelW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, cap}) begin
      s = s - {1'b0, cap};
    end
    return s[LevelW-1:0];
  endfunction

  // Byte store.
  logic [ByteW-1:0] mem [DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [ByteW-1:0] mem_wd;
  logic             mem_re;
  logic [AW-1:0]    mem_ra;
  logic [ByteW-1:0] rd_q;

  // Control state.
  state_e            state_q, state_d;
  logic [LevelW-1:0] cap_q, cap_d;
  logic [LevelW-1:0] head_q, head_d;
  logic [LevelW-1:0] fill_q, fill_d;
  logic [LevelW-1:0] rptr_q, rptr_d;
  logic [CountW-1:0] rem_q, rem_d;

  // Stage one sits beside the memory read register; stage two drives the port.
  logic              s1_v_q, s1_v_d;
  rec_t              s1_q, s1_d;
  logic              ov_q, ov_d;
  rec_t              out_q, out_d;
  logic [ByteW-1:0]  obyte_q, obyte_d;

  logic              mv;
  logic              adv;

  // Input fields.
  op_e               in_op;
  logic [ByteW-1:0]  in_byte;
  logic [CountW-1:0] in_count;

  assign in_op    = op_e'(s_axis_tuser);
  assign in_byte  = s_axis_tdata[7:0];
  assign in_count = s_axis_tdata[14:8];

  // A stage-one record moves on when the output register is free or drains.
  assign mv  = s1_v_q && (!ov_q || m_axis_tready);
  assign adv = !s1_v_q || mv;

  assign s_axis_tready = (state_q == ST_IDLE) && adv && !cfg_we_i;

  always_comb begin
    logic [CountW-1:0] req;
    logic [CountW-1:0] n;
    logic [LevelW-1:0] cfg_cap;
    logic              full;
    logic              take;
    rec_t              rec;

    state_d = state_q;
    cap_d   = cap_q;
    head_d  = head_q;
    fill_d  = fill_q;
    rptr_d  = rptr_q;
    rem_d   = rem_q;

    mem_we = 1'b0;
    mem_wa = AW'(head_q);
    mem_wd = in_byte;
    mem_re = 1'b0;
    mem_ra = AW'(head_q);

    req = (in_count > BurstMax) ? BurstMax : in_count;
    n   = ({2'b0, req} < fill_q) ? req : fill_q[CountW-1:0];
    full = (fill_q >= cap_q);
    take = s_axis_tvalid && s_axis_tready;

    rec      = '0;
    rec.last = 1'b1;
    s1_d     = s1_q;
    s1_v_d   = s1_v_q && !mv;

    cfg_cap = cfg_wdata_i;
    if (cfg_cap == '0) begin
      cfg_cap = LevelW'(1);
    end
    if (int'(cfg_cap) > int'(DEPTH)) begin
      cfg_cap = LevelW'(DEPTH);
    end

    case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          cap_d  = cfg_cap;
          head_d = '0;
          fill_d = '0;
        end else if (take) begin
          case (in_op)
            OP_PUSH_OVR: begin
              rec.accepted = 1'b1;
              mem_we = 1'b1;
              if (full) begin
                // The tail lands on the oldest byte, read out in the same cycle.
                mem_re = 1'b1;
                mem_wa = AW'(head_q);
                rec.byte_valid = 1'b1;
                head_d = wrap_add(head_q, LevelW'(1), cap_q);
              end else begin
                mem_wa = AW'(wrap_add(head_q, fill_q, cap_q));
                fill_d = fill_q + LevelW'(1);
              end
            end
            OP_PUSH_ROOM: begin
              if (!full) begin
                mem_we = 1'b1;
                mem_wa = AW'(wrap_add(head_q, fill_q, cap_q));
                fill_d = fill_q + LevelW'(1);
                rec.accepted = 1'b1;
              end
            end
            OP_POP, OP_PEEK: begin
              if (n != '0) begin
                mem_re = 1'b1;
                rec.byte_valid = 1'b1;
                rec.last = (n == CountW'(1));
                rptr_d = wrap_add(head_q, LevelW'(1), cap_q);
                rem_d  = n - CountW'(1);
                if (n != CountW'(1)) begin
                  state_d = ST_BURST;
                end
                if (in_op == OP_POP) begin
                  fill_d = fill_q - {2'b0, n};
                  head_d = (fill_d == '0) ? '0 : wrap_add(head_q, {2'b0, n}, cap_q);
                end
              end
            end
            OP_DROP: begin
              fill_d = fill_q - {2'b0, n};
              head_d = (fill_d == '0) ? '0 : wrap_add(head_q, {2'b0, n}, cap_q);
              rec.done_count = n;
            end
            default: begin
            end
          endcase
          rec.fill_level = fill_d;
          s1_d   = rec;
          s1_v_d = 1'b1;
        end
      end
      ST_BURST: begin
        if (adv) begin
          mem_re = 1'b1;
          mem_ra = AW'(rptr_q);
          rec.byte_valid = 1'b1;
          rec.last = (rem_q == CountW'(1));
          rec.fill_level = fill_q;
          s1_d   = rec;
          s1_v_d = 1'b1;
          rptr_d = wrap_add(rptr_q, LevelW'(1), cap_q);
          rem_d  = rem_q - CountW'(1);
          if (rem_q == CountW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Output register.
    out_d   = out_q;
    obyte_d = obyte_q;
    ov_d    = ov_q && !m_axis_tready;
    if (mv) begin
      out_d   = s1_q;
      obyte_d = s1_q.byte_valid ? rd_q : '0;
      ov_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= CapRst;
      head_q  <= '0;
      fill_q  <= '0;
      rptr_q  <= '0;
      rem_q   <= '0;
      s1_v_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      rptr_q  <= rptr_d;
      rem_q   <= rem_d;
      s1_v_q  <= s1_v_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= s1_d;
    out_q   <= out_d;
    obyte_q <= obyte_d;
  end

  // Read and write in one clocked block: a read of the entry being written
  // returns the old byte, which is what an overwrite push reports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {out_q.fill_level, out_q.done_count, obyte_q};
  assign m_axis_tuser  = {out_q.accepted, out_q.byte_valid};
  assign m_axis_tlast  = out_q.last;

endmodule
